FILE: src/modular_mul_exp_unit_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the modular multiply and exponent unit
// Same-cycle and next-cycle implication checks on clk with rst_n disable.
// ---------------------------------------------------------------------------
`ifndef MODULAR_MUL_EXP_UNIT_TOP_ASSERT_SVH
`define MODULAR_MUL_EXP_UNIT_TOP_ASSERT_SVH

// check cons in the same cycle as ante
`define MME_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mme: same-cycle check failed");

// check cons in the cycle after ante
`define MME_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mme: next-cycle check failed");

`endif

FILE: src/mme_pkg.sv
// ---------------------------------------------------------------------------
// mme_pkg
// Widths, opcodes, reset constants and controller/datapath command and status types.
// ---------------------------------------------------------------------------
package mme_pkg;

    localparam int MOD_W  = 62;
    localparam int OPND_W = 64;
    localparam int OP_W   = 2;
    localparam int K_W    = 6;
    localparam int CNT_W  = 7;
    localparam int PROD_W = 128;
    localparam int HALF_W = 32;

    localparam logic [OP_W-1:0] OP_MUL  = 2'd0;
    localparam logic [OP_W-1:0] OP_POW  = 2'd1;
    localparam logic [OP_W-1:0] OP_ROOT = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam logic [MOD_W-1:0]  MOD_RST   = 62'd2;
    localparam logic [K_W-1:0]    K_RST     = 6'd2;
    localparam logic [K_W-1:0]    K_MAX     = 6'd62;
    localparam logic [OPND_W-1:0] MU_RST    = 64'd8;
    localparam logic [CNT_W-1:0]  RED_STEPS = 7'd63;

    typedef struct packed {
        logic accept;
        logic step_scan;
        logic ld_div_mu;
        logic step_div;
        logic sav_mu;
        logic sav_a;
        logic ld_red_b;
        logic sav_b;
        logic ld_pow;
        logic pow_half;
        logic mm_start;
        logic mm_sq;
        logic exp_shift;
        logic fin;
        logic fin_zero;
        logic fin_root;
    } cmd_t;

    typedef struct packed {
        logic scan_msb;
        logic cnt_zero;
        logic a_zero;
        logic mm_done;
        logic exp_zero;
        logic exp_lsb;
    } sts_t;

endpackage

FILE: src/mme_barrett.sv
// ---------------------------------------------------------------------------
// mme_barrett
// Barrett modular multiplier on one shared 32x32 multiplier: three 64x64
// products of four partials each, then subtract and two conditional fixes.
// ---------------------------------------------------------------------------
module mme_barrett
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mme_pkg::MOD_W-1:0]    a_in,
    input  logic [mme_pkg::MOD_W-1:0]    b_in,
    input  logic [mme_pkg::MOD_W-1:0]    modulus,
    input  logic [mme_pkg::K_W-1:0]      k,
    input  logic [mme_pkg::OPND_W-1:0]   mu,
    output logic                         done,
    output logic [mme_pkg::MOD_W-1:0]    res
);
    import mme_pkg::*;

    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001,
        B_MUL  = 7'b0000010,
        B_SH1  = 7'b0000100,
        B_SH2  = 7'b0001000,
        B_SUB  = 7'b0010000,
        B_FIX1 = 7'b0100000,
        B_FIX2 = 7'b1000000
    } b_state_t;

    localparam logic [1:0] PASS_AB = 2'd0;
    localparam logic [1:0] PASS_T  = 2'd1;
    localparam logic [1:0] PASS_Q  = 2'd2;
    localparam logic [2:0] PP_LAST = 3'd4;

    b_state_t             state_reg, state_next;
    logic [1:0]           pass_reg, pass_next;
    logic [2:0]           cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [OPND_W-1:0]    op_a_reg, op_a_next;
    logic [OPND_W-1:0]    op_b_reg, op_b_next;
    logic [OPND_W-1:0]    pp_reg, pp_next;
    logic [1:0]           pp_sh_reg, pp_sh_next;
    logic [PROD_W-1:0]    acc_reg, acc_next;
    logic [OPND_W-1:0]    x_lo_reg, x_lo_next;
    logic [OPND_W-1:0]    r_reg, r_next;

    logic [1:0]           idx;
    logic [HALF_W-1:0]    a_half;
    logic [HALF_W-1:0]    b_half;
    logic [OPND_W-1:0]    pp_full;
    logic [PROD_W-1:0]    pp_shifted;
    logic [PROD_W-1:0]    sh1;
    logic [PROD_W-1:0]    sh2;
    logic [OPND_W-1:0]    mod64;
    logic [OPND_W-1:0]    r_fix;

    assign idx     = cnt_reg[1:0];
    assign a_half  = idx[0] ? op_a_reg[OPND_W-1:HALF_W] : op_a_reg[HALF_W-1:0];
    assign b_half  = idx[1] ? op_b_reg[OPND_W-1:HALF_W] : op_b_reg[HALF_W-1:0];
    assign pp_full = {{HALF_W{1'b0}}, a_half} * {{HALF_W{1'b0}}, b_half};
    assign sh1     = acc_reg >> (k - 6'd1);
    assign sh2     = acc_reg >> (k + 6'd1);
    assign mod64   = {2'b00, modulus};
    assign r_fix   = (r_reg >= mod64) ? (r_reg - mod64) : r_reg;

    always_comb
    begin
        case (pp_sh_reg)
            2'd1:    pp_shifted = {32'd0, pp_reg, 32'd0};
            2'd2:    pp_shifted = {pp_reg, 64'd0};
            default: pp_shifted = {64'd0, pp_reg};
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        op_a_next  = op_a_reg;
        op_b_next  = op_b_reg;
        pp_next    = pp_reg;
        pp_sh_next = pp_sh_reg;
        acc_next   = acc_reg;
        x_lo_next  = x_lo_reg;
        r_next     = r_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    op_a_next  = {2'b00, a_in};
                    op_b_next  = {2'b00, b_in};
                    acc_next   = '0;
                    cnt_next   = 3'd0;
                    pass_next  = PASS_AB;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                if (cnt_reg != PP_LAST)
                begin
                    pp_next    = pp_full;
                    pp_sh_next = {1'b0, idx[0]} + {1'b0, idx[1]};
                end
                if (cnt_reg != 3'd0)
                begin
                    acc_next = acc_reg + pp_shifted;
                end
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == PP_LAST)
                begin
                    case (pass_reg)
                        PASS_AB: state_next = B_SH1;
                        PASS_T:  state_next = B_SH2;
                        default: state_next = B_SUB;
                    endcase
                end
            end
            B_SH1:
            begin
                x_lo_next  = acc_reg[OPND_W-1:0];
                op_a_next  = sh1[OPND_W-1:0];
                op_b_next  = mu;
                acc_next   = '0;
                cnt_next   = 3'd0;
                pass_next  = PASS_T;
                state_next = B_MUL;
            end
            B_SH2:
            begin
                op_a_next  = sh2[OPND_W-1:0];
                op_b_next  = mod64;
                acc_next   = '0;
                cnt_next   = 3'd0;
                pass_next  = PASS_Q;
                state_next = B_MUL;
            end
            B_SUB:
            begin
                r_next     = x_lo_reg - acc_reg[OPND_W-1:0];
                state_next = B_FIX1;
            end
            B_FIX1:
            begin
                r_next     = r_fix;
                state_next = B_FIX2;
            end
            B_FIX2:
            begin
                r_next     = r_fix;
                done_next  = 1'b1;
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            pass_reg  <= PASS_AB;
            cnt_reg   <= 3'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_a_reg  <= op_a_next;
        op_b_reg  <= op_b_next;
        pp_reg    <= pp_next;
        pp_sh_reg <= pp_sh_next;
        acc_reg   <= acc_next;
        x_lo_reg  <= x_lo_next;
        r_reg     <= r_next;
    end

    assign done = done_reg;
    assign res  = r_reg[MOD_W-1:0];

endmodule

FILE: src/mme_dp.sv
// ---------------------------------------------------------------------------
// mme_dp
// Datapath: modulus and Barrett constants, bit-serial reducer and divider,
// exponent registers, Barrett multiplier and the result registers.
// ---------------------------------------------------------------------------
`include "modular_mul_exp_unit_top_assert.svh"

module mme_dp
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [mme_pkg::MOD_W-1:0]    cfg_data,
    input  logic [mme_pkg::OPND_W-1:0]   operand_a,
    input  logic [mme_pkg::OPND_W-1:0]   operand_b,
    input  mme_pkg::cmd_t                cmd,
    output mme_pkg::sts_t                sts,
    output logic                         done,
    output logic [mme_pkg::MOD_W-1:0]    value,
    output logic                         is_root
);
    import mme_pkg::*;

    logic [MOD_W-1:0]   mod_reg, mod_next;
    logic [K_W-1:0]     k_reg, k_next;
    logic [OPND_W-1:0]  mu_reg, mu_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               mm_sq_reg, mm_sq_next;
    logic               done_reg, done_next;
    logic [MOD_W-1:0]   scan_reg, scan_next;
    logic [MOD_W-1:0]   rem_reg, rem_next;
    logic [OPND_W-1:0]  shf_reg, shf_next;
    logic [OPND_W-1:0]  quo_reg, quo_next;
    logic [OPND_W-1:0]  a_reg, a_next;
    logic [OPND_W-1:0]  b_reg, b_next;
    logic [MOD_W-1:0]   base_reg, base_next;
    logic [MOD_W-1:0]   acc_reg, acc_next;
    logic [OPND_W-1:0]  exp_reg, exp_next;
    logic [MOD_W-1:0]   value_reg, value_next;
    logic               is_root_reg, is_root_next;

    logic [MOD_W-1:0]   cfg_sat;
    logic [MOD_W:0]     tr;
    logic [MOD_W:0]     diff;
    logic               ge;
    logic [MOD_W-1:0]   rem_step;
    logic [OPND_W-1:0]  quo_step;
    logic [MOD_W-1:0]   mm_a;
    logic [MOD_W-1:0]   mm_res;
    logic               mm_done;

    assign cfg_sat  = (cfg_data < MOD_RST) ? MOD_RST : cfg_data;
    assign tr       = {rem_reg, shf_reg[OPND_W-1]};
    assign diff     = tr - {1'b0, mod_reg};
    assign ge       = tr >= {1'b0, mod_reg};
    assign rem_step = ge ? diff[MOD_W-1:0] : tr[MOD_W-1:0];
    assign quo_step = {quo_reg[OPND_W-2:0], ge};
    assign mm_a     = cmd.mm_sq ? base_reg : acc_reg;

    mme_barrett u_barrett
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mm_start),
        .a_in    (mm_a),
        .b_in    (base_reg),
        .modulus (mod_reg),
        .k       (k_reg),
        .mu      (mu_reg),
        .done    (mm_done),
        .res     (mm_res)
    );

    always_comb
    begin
        mod_next     = mod_reg;
        k_next       = k_reg;
        mu_next      = mu_reg;
        cnt_next     = cnt_reg;
        mm_sq_next   = mm_sq_reg;
        done_next    = cmd.fin;
        scan_next    = scan_reg;
        rem_next     = rem_reg;
        shf_next     = shf_reg;
        quo_next     = quo_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        base_next    = base_reg;
        acc_next     = acc_reg;
        exp_next     = exp_reg;
        value_next   = value_reg;
        is_root_next = is_root_reg;

        if (cfg_we)
        begin
            mod_next  = cfg_sat;
            scan_next = cfg_sat;
            k_next    = K_MAX;
        end
        if (cmd.step_scan)
        begin
            scan_next = scan_reg << 1;
            k_next    = k_reg - 6'd1;
        end
        if (cmd.step_div)
        begin
            rem_next = rem_step;
            shf_next = shf_reg << 1;
            quo_next = quo_step;
            cnt_next = cnt_reg - 7'd1;
        end
        if (cmd.ld_div_mu)
        begin
            rem_next = '0;
            shf_next = {1'b1, 63'd0};
            quo_next = '0;
            cnt_next = {k_reg, 1'b0};
        end
        if (cmd.accept)
        begin
            a_next   = operand_a;
            b_next   = operand_b;
            rem_next = '0;
            shf_next = operand_a;
            cnt_next = RED_STEPS;
        end
        if (cmd.ld_red_b)
        begin
            rem_next = '0;
            shf_next = b_reg;
            cnt_next = RED_STEPS;
        end
        if (cmd.sav_mu)
        begin
            mu_next = quo_step;
        end
        if (cmd.sav_a)
        begin
            base_next = rem_step;
        end
        if (cmd.sav_b)
        begin
            acc_next = rem_step;
        end
        if (cmd.ld_pow)
        begin
            acc_next = 62'd1;
            exp_next = cmd.pow_half ? (b_reg >> 1) : b_reg;
        end
        if (cmd.mm_start)
        begin
            mm_sq_next = cmd.mm_sq;
        end
        if (mm_done)
        begin
            if (mm_sq_reg)
            begin
                base_next = mm_res;
            end
            else
            begin
                acc_next = mm_res;
            end
        end
        if (cmd.exp_shift)
        begin
            exp_next = exp_reg >> 1;
        end
        if (cmd.fin)
        begin
            value_next   = cmd.fin_zero ? '0 : acc_reg;
            is_root_next = !cmd.fin_zero && cmd.fin_root && (acc_reg == mod_reg - 62'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg   <= MOD_RST;
            k_reg     <= K_RST;
            mu_reg    <= MU_RST;
            cnt_reg   <= '0;
            mm_sq_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            mod_reg   <= mod_next;
            k_reg     <= k_next;
            mu_reg    <= mu_next;
            cnt_reg   <= cnt_next;
            mm_sq_reg <= mm_sq_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        rem_reg     <= rem_next;
        shf_reg     <= shf_next;
        quo_reg     <= quo_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        base_reg    <= base_next;
        acc_reg     <= acc_next;
        exp_reg     <= exp_next;
        value_reg   <= value_next;
        is_root_reg <= is_root_next;
    end

    assign sts.scan_msb = scan_reg[MOD_W-1];
    assign sts.cnt_zero = (cnt_reg == '0);
    assign sts.a_zero   = (a_reg == '0);
    assign sts.mm_done  = mm_done;
    assign sts.exp_zero = (exp_reg == '0);
    assign sts.exp_lsb  = exp_reg[0];

    assign done    = done_reg;
    assign value   = value_reg;
    assign is_root = is_root_reg;

    `MME_ASSERT_NOW(a_mm_res_range, mm_done, mm_res < mod_reg)
    `MME_ASSERT_NOW(a_root_value, done_reg && is_root_reg, value_reg == mod_reg - 62'd1)

endmodule

FILE: src/mme_ctrl.sv
// ---------------------------------------------------------------------------
// mme_ctrl
// Controller: modulus setup, operand reduction, square-and-multiply loop
// and result transfer.
// ---------------------------------------------------------------------------
`include "modular_mul_exp_unit_top_assert.svh"

module mme_ctrl
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [mme_pkg::OP_W-1:0]   opcode,
    input  logic                       cfg_we,
    input  mme_pkg::sts_t              sts,
    output mme_pkg::cmd_t              cmd,
    output logic                       busy
);
    import mme_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_FIND_K   = 11'b00000000010,
        S_DIV_MU   = 11'b00000000100,
        S_RED_A    = 11'b00000001000,
        S_RED_B    = 11'b00000010000,
        S_MUL_GO   = 11'b00000100000,
        S_MUL_WAIT = 11'b00001000000,
        S_POW_CHK  = 11'b00010000000,
        S_POW_MUL  = 11'b00100000000,
        S_POW_SQR  = 11'b01000000000,
        S_FIN      = 11'b10000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic             zero_reg, zero_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        op_next    = op_reg;
        zero_next  = zero_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    state_next = S_FIND_K;
                end
                else if (start)
                begin
                    cmd.accept = 1'b1;
                    op_next    = opcode;
                    zero_next  = 1'b0;
                    unique case (opcode) inside
                        OP_MUL, OP_POW, OP_ROOT:
                        begin
                            state_next = S_RED_A;
                        end
                        OP_NONE:
                        begin
                            zero_next  = 1'b1;
                            state_next = S_FIN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FIND_K:
            begin
                if (cfg_we)
                begin
                    state_next = S_FIND_K;
                end
                else if (sts.scan_msb)
                begin
                    cmd.ld_div_mu = 1'b1;
                    state_next    = S_DIV_MU;
                end
                else
                begin
                    cmd.step_scan = 1'b1;
                end
            end
            S_DIV_MU:
            begin
                if (cfg_we)
                begin
                    state_next = S_FIND_K;
                end
                else
                begin
                    cmd.step_div = 1'b1;
                    if (sts.cnt_zero)
                    begin
                        cmd.sav_mu = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_RED_A:
            begin
                cmd.step_div = 1'b1;
                if (sts.cnt_zero)
                begin
                    cmd.sav_a = 1'b1;
                    if (op_reg == OP_MUL)
                    begin
                        cmd.ld_red_b = 1'b1;
                        state_next   = S_RED_B;
                    end
                    else if ((op_reg == OP_ROOT) && sts.a_zero)
                    begin
                        zero_next  = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.ld_pow   = 1'b1;
                        cmd.pow_half = (op_reg == OP_ROOT);
                        state_next   = S_POW_CHK;
                    end
                end
            end
            S_RED_B:
            begin
                cmd.step_div = 1'b1;
                if (sts.cnt_zero)
                begin
                    cmd.sav_b  = 1'b1;
                    state_next = S_MUL_GO;
                end
            end
            S_MUL_GO:
            begin
                cmd.mm_start = 1'b1;
                state_next   = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (sts.mm_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_POW_CHK:
            begin
                if (sts.exp_zero)
                begin
                    state_next = S_FIN;
                end
                else if (sts.exp_lsb)
                begin
                    cmd.mm_start = 1'b1;
                    state_next   = S_POW_MUL;
                end
                else
                begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_sq    = 1'b1;
                    state_next   = S_POW_SQR;
                end
            end
            S_POW_MUL:
            begin
                if (sts.mm_done)
                begin
                    cmd.mm_start = 1'b1;
                    cmd.mm_sq    = 1'b1;
                    state_next   = S_POW_SQR;
                end
            end
            S_POW_SQR:
            begin
                if (sts.mm_done)
                begin
                    cmd.exp_shift = 1'b1;
                    state_next    = S_POW_CHK;
                end
            end
            S_FIN:
            begin
                cmd.fin      = 1'b1;
                cmd.fin_zero = zero_reg;
                cmd.fin_root = (op_reg == OP_ROOT);
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_MUL;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            zero_reg  <= zero_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    `MME_ASSERT_NEXT(a_accept_busy, start && !busy && !cfg_we, busy)
    `MME_ASSERT_NEXT(a_cfg_busy, cfg_we && !busy, busy)
    `MME_ASSERT_NOW(a_mm_done_wait, sts.mm_done,
                    state_reg == S_MUL_WAIT || state_reg == S_POW_MUL || state_reg == S_POW_SQR)

endmodule

FILE: src/modular_mul_exp_unit_top.sv
// ---------------------------------------------------------------------------
// modular_mul_exp_unit_top
// Modular multiply, power and power-of-two primitive root test over a
// configured modulus, Barrett reduction on a shared 32x32 multiplier.
//
//   channel   direction   handshake          fields
//   config    in          cfg_we             cfg_data (modulus)
//   command   in          start / busy       opcode, operand_a, operand_b
//   result    out         done (one cycle)   value, is_root
//
// Each operand reduction is bit-serial; a Barrett multiply forms three 64x64
// products of four 32x32 partials. Multiply reduces both operands, then
// multiplies them. Power and root test reduce operand_a, then square once per
// exponent bit and multiply once more per set bit. A modulus write keeps busy
// high while the bit length search and the Barrett constant division run.
// Reset loads modulus 2 with its constants; no clearing pass. done cannot
// be stalled: the result is valid for the single cycle that done is high.
// ---------------------------------------------------------------------------
module modular_mul_exp_unit_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [mme_pkg::MOD_W-1:0]    cfg_data,
    input  logic                         start,
    output logic                         busy,
    input  logic [mme_pkg::OP_W-1:0]     opcode,
    input  logic [mme_pkg::OPND_W-1:0]   operand_a,
    input  logic [mme_pkg::OPND_W-1:0]   operand_b,
    output logic                         done,
    output logic [mme_pkg::MOD_W-1:0]    value,
    output logic                         is_root
);
    import mme_pkg::*;

    cmd_t cmd;
    sts_t sts;

    mme_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .cfg_we (cfg_we),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    mme_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .cmd       (cmd),
        .sts       (sts),
        .done      (done),
        .value     (value),
        .is_root   (is_root)
    );

endmodule
